@@ rtl/npag_pkg.sv @@
// shared types and codes for the nine-patch address generator
package npag_pkg;

	localparam int REG_W  = 13;   // configuration register width
	localparam int DIM_W  = 12;   // content size field width
	localparam int MAP_W  = 14;   // mapped source coordinate width
	localparam int IDX_W  = 24;   // pixel index width
	localparam int STAT_W = 2;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// register map, word index into the apb space
	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH     = 3'd0,
		REG_IMAGE_HEIGHT    = 3'd1,
		REG_STRETCH_X_BEGIN = 3'd2,
		REG_STRETCH_X_END   = 3'd3,
		REG_STRETCH_Y_BEGIN = 3'd4,
		REG_STRETCH_Y_END   = 3'd5,
		REG_TARGET_PITCH    = 3'd6,
		REG_TARGET_ROWS     = 3'd7
	} reg_idx_t;

	// result status codes
	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_SMALL = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_IDLE  = 2'd2;

	// command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// register file contents
	typedef struct packed {
		logic [REG_W-1:0] image_width;
		logic [REG_W-1:0] image_height;
		logic [REG_W-1:0] stretch_x_begin;
		logic [REG_W-1:0] stretch_x_end;
		logic [REG_W-1:0] stretch_y_begin;
		logic [REG_W-1:0] stretch_y_end;
		logic [REG_W-1:0] target_pitch;
		logic [REG_W-1:0] target_rows;
	} cfg_t;

	// one beat between the position stage and the index stage
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [MAP_W-1:0]  src_row;
		logic [MAP_W-1:0]  src_col;
		logic [REG_W-1:0]  dst_row;
		logic [REG_W-1:0]  dst_col;
		logic              row_end;
		logic              frame_end;
	} pix_t;

endpackage

@@ rtl/npag_regs.sv @@
// apb configuration registers
module npag_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [npag_pkg::ADDR_W-1:0]   paddr,
	input  logic [npag_pkg::DATA_W-1:0]   pwdata,
	output logic [npag_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output npag_pkg::cfg_t                cfg
);
	import npag_pkg::*;

	cfg_t         cfg_q;
	reg_idx_t     idx;
	logic         wr_en;
	logic [REG_W-1:0] wdata;
	logic [REG_W-1:0] rdata;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign wdata  = pwdata[REG_W-1:0];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= REG_W'(1);
			cfg_q.image_height    <= REG_W'(1);
			cfg_q.stretch_x_begin <= '0;
			cfg_q.stretch_x_end   <= REG_W'(1);
			cfg_q.stretch_y_begin <= '0;
			cfg_q.stretch_y_end   <= REG_W'(1);
			cfg_q.target_pitch    <= REG_W'(1);
			cfg_q.target_rows     <= REG_W'(1);
		end else if (wr_en) begin
			case (idx)
				REG_IMAGE_WIDTH:     cfg_q.image_width     <= wdata;
				REG_IMAGE_HEIGHT:    cfg_q.image_height    <= wdata;
				REG_STRETCH_X_BEGIN: cfg_q.stretch_x_begin <= wdata;
				REG_STRETCH_X_END:   cfg_q.stretch_x_end   <= wdata;
				REG_STRETCH_Y_BEGIN: cfg_q.stretch_y_begin <= wdata;
				REG_STRETCH_Y_END:   cfg_q.stretch_y_end   <= wdata;
				REG_TARGET_PITCH:    cfg_q.target_pitch    <= wdata;
				REG_TARGET_ROWS:     cfg_q.target_rows     <= wdata;
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_IMAGE_WIDTH:     rdata = cfg_q.image_width;
			REG_IMAGE_HEIGHT:    rdata = cfg_q.image_height;
			REG_STRETCH_X_BEGIN: rdata = cfg_q.stretch_x_begin;
			REG_STRETCH_X_END:   rdata = cfg_q.stretch_x_end;
			REG_STRETCH_Y_BEGIN: rdata = cfg_q.stretch_y_begin;
			REG_STRETCH_Y_END:   rdata = cfg_q.stretch_y_end;
			REG_TARGET_PITCH:    rdata = cfg_q.target_pitch;
			REG_TARGET_ROWS:     rdata = cfg_q.target_rows;
			default:             rdata = '0;
		endcase
	end

	assign prdata = DATA_W'(rdata);

endmodule

@@ rtl/npag_ctrl.sv @@
// frame state, raster position and coordinate mapping stage
module npag_ctrl #(
	parameter int MAX_DIM = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  npag_pkg::cfg_t              cfg,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        cmd,
	input  logic [npag_pkg::DIM_W-1:0]  content_cols,
	input  logic [npag_pkg::DIM_W-1:0]  content_rows,
	input  logic                        blocked,
	output logic                        pix_valid,
	output npag_pkg::pix_t              pix
);
	import npag_pkg::*;

	localparam int          LIM_W   = 18;
	localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_DIM);

	// map one output coordinate to its source coordinate along one axis
	function automatic logic [MAP_W-1:0] map_axis(
		input logic [REG_W-1:0] pos,
		input logic [REG_W-1:0] first,
		input logic [MAP_W-1:0] edge_pos,
		input logic [REG_W-1:0] last
	);
		logic [MAP_W-1:0] res;
		if (pos < first)
			res = MAP_W'(pos);
		else if (MAP_W'(pos) >= edge_pos)
			res = MAP_W'(pos) - edge_pos + MAP_W'(last);
		else
			res = MAP_W'(first);
		return res;
	endfunction

	// frame state
	logic [REG_W-1:0] out_row_q, out_col_q, out_width_q, out_height_q;
	logic [MAP_W-1:0] right_edge_q, bottom_edge_q;
	logic             frame_active_q;

	// stage 1 register
	logic pix_valid_s1;
	pix_t pix_s1;

	logic        advance, accept;
	logic [15:0] w_s, h_s;
	logic        reject;
	logic        last_col, last_row;
	pix_t        pix_d;

	assign advance   = !pix_valid_s1 || !blocked;
	assign req_stall = !advance;
	assign accept    = req_valid && advance;

	// output size, two's complement over 16 bits
	assign w_s = 16'(content_cols) + 16'(cfg.image_width)
	           - 16'(cfg.stretch_x_end) + 16'(cfg.stretch_x_begin);
	assign h_s = 16'(content_rows) + 16'(cfg.image_height)
	           - 16'(cfg.stretch_y_end) + 16'(cfg.stretch_y_begin);

	// negative, larger than the buffer, or larger than the limit
	assign reject = w_s[15] || h_s[15]
	             || (w_s[14:0] > 15'(cfg.target_pitch))
	             || (h_s[14:0] > 15'(cfg.target_rows))
	             || (LIM_W'(w_s[14:0]) > MAX_LIM)
	             || (LIM_W'(h_s[14:0]) > MAX_LIM);

	assign last_col = ((MAP_W'(out_col_q) + MAP_W'(1)) == MAP_W'(out_width_q));
	assign last_row = ((MAP_W'(out_row_q) + MAP_W'(1)) == MAP_W'(out_height_q));

	// result of the current item
	always_comb begin
		pix_d = '0;
		if (cmd == CMD_START) begin
			pix_d.status = reject ? STATUS_SMALL : STATUS_OK;
		end else if (!frame_active_q) begin
			pix_d.status = STATUS_IDLE;
		end else begin
			pix_d.status    = STATUS_OK;
			pix_d.src_col   = map_axis(out_col_q, cfg.stretch_x_begin, right_edge_q,
			                           cfg.stretch_x_end);
			pix_d.src_row   = map_axis(out_row_q, cfg.stretch_y_begin, bottom_edge_q,
			                           cfg.stretch_y_end);
			pix_d.dst_row   = out_row_q;
			pix_d.dst_col   = out_col_q;
			pix_d.row_end   = last_col;
			pix_d.frame_end = last_col && last_row;
		end
	end

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_row_q      <= '0;
			out_col_q      <= '0;
			out_width_q    <= '0;
			out_height_q   <= '0;
			right_edge_q   <= '0;
			bottom_edge_q  <= '0;
			frame_active_q <= 1'b0;
		end else if (accept) begin
			if (cmd == CMD_START) begin
				out_row_q <= '0;
				out_col_q <= '0;
				if (reject) begin
					frame_active_q <= 1'b0;
				end else begin
					out_width_q    <= w_s[REG_W-1:0];
					out_height_q   <= h_s[REG_W-1:0];
					right_edge_q   <= MAP_W'(content_cols) + MAP_W'(cfg.stretch_x_begin);
					bottom_edge_q  <= MAP_W'(content_rows) + MAP_W'(cfg.stretch_y_begin);
					frame_active_q <= (w_s != '0) && (h_s != '0);
				end
			end else if (frame_active_q) begin
				if (last_col) begin
					out_col_q <= '0;
					if (last_row) begin
						out_row_q      <= '0;
						frame_active_q <= 1'b0;
					end else begin
						out_row_q <= out_row_q + REG_W'(1);
					end
				end else begin
					out_col_q <= out_col_q + REG_W'(1);
				end
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s1 <= 1'b0;
		end else if (advance) begin
			pix_valid_s1 <= req_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix_d;
		end
	end

	assign pix_valid = pix_valid_s1;
	assign pix       = pix_s1;

`ifndef SYNTHESIS
	// last pixel of a frame is always last of its row
	a_frame_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid_s1 && pix_s1.frame_end |-> pix_s1.row_end)
		else $error("frame_end without row_end");

	// raster position stays inside the active frame
	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		frame_active_q |-> (out_col_q < out_width_q) && (out_row_q < out_height_q))
		else $error("raster position outside frame");

	// a rejected start leaves no frame active
	a_reject_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == CMD_START) && reject |=> !frame_active_q)
		else $error("frame active after rejected start");

	// a held stage 1 beat does not change
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid_s1 && blocked |=> pix_valid_s1 && $stable(pix_s1))
		else $error("stage 1 beat changed while held");
`endif

endmodule

@@ rtl/npag_index.sv @@
// index multipliers and result register
module npag_index (
	input  logic                         clk,
	input  logic                         arst_n,
	input  npag_pkg::cfg_t               cfg,
	input  logic                         pix_valid,
	input  npag_pkg::pix_t               pix,
	output logic                         blocked,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [npag_pkg::STAT_W-1:0]  status,
	output logic [npag_pkg::IDX_W-1:0]   src_index,
	output logic [npag_pkg::IDX_W-1:0]   dst_index,
	output logic                         row_end,
	output logic                         frame_end
);
	import npag_pkg::*;

	localparam int SRC_P_W = MAP_W + REG_W;
	localparam int DST_P_W = 2 * REG_W;

	logic               rsp_valid_s2;
	logic [STAT_W-1:0]  status_s2;
	logic [IDX_W-1:0]   src_s2, dst_s2;
	logic               row_end_s2, frame_end_s2;
	logic [SRC_P_W-1:0] src_full;
	logic [DST_P_W-1:0] dst_full;

	assign blocked = rsp_valid_s2 && rsp_stall;

	// row times stride plus column, kept to the index width
	assign src_full = SRC_P_W'(pix.src_row) * SRC_P_W'(cfg.image_width)
	                + SRC_P_W'(pix.src_col);
	assign dst_full = DST_P_W'(pix.dst_row) * DST_P_W'(cfg.target_pitch)
	                + DST_P_W'(pix.dst_col);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (!blocked) begin
			rsp_valid_s2 <= pix_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (!blocked && pix_valid) begin
			status_s2    <= pix.status;
			src_s2       <= src_full[IDX_W-1:0];
			dst_s2       <= dst_full[IDX_W-1:0];
			row_end_s2   <= pix.row_end;
			frame_end_s2 <= pix.frame_end;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign status    = status_s2;
	assign src_index = src_s2;
	assign dst_index = dst_s2;
	assign row_end   = row_end_s2;
	assign frame_end = frame_end_s2;

endmodule

@@ rtl/nine_patch_address_generator.sv @@
// nine-patch address generator top level
// Returns one response beat per request, in order, via the stage 1 and result registers.
// A start beat (cmd 0) sizes a frame from the content size and the image borders and
// answers ok or buffer too small; each step beat (cmd 1) returns the destination and
// source index of the next output pixel in raster order, or no frame active. Throughput
// is one beat per cycle, set by the position stage and the index multiplier stage; a
// stalled response holds the pipeline, and a request is still taken while it has an
// empty slot. Users must write registers over apb only while idle; this is not checked.
module nine_patch_address_generator #(
	parameter int MAX_DIM = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [npag_pkg::ADDR_W-1:0]   paddr,
	input  logic [npag_pkg::DATA_W-1:0]   pwdata,
	output logic [npag_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          cmd,
	input  logic [npag_pkg::DIM_W-1:0]    content_cols,
	input  logic [npag_pkg::DIM_W-1:0]    content_rows,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [npag_pkg::STAT_W-1:0]   status,
	output logic [npag_pkg::IDX_W-1:0]    src_index,
	output logic [npag_pkg::IDX_W-1:0]    dst_index,
	output logic                          row_end,
	output logic                          frame_end
);
	import npag_pkg::*;

	cfg_t cfg;
	pix_t pix;
	logic pix_valid;
	logic blocked;

	// configuration registers
	npag_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// frame state and coordinate mapping
	npag_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.cmd          (cmd),
		.content_cols (content_cols),
		.content_rows (content_rows),
		.blocked      (blocked),
		.pix_valid    (pix_valid),
		.pix          (pix)
	);

	// index computation and response register
	npag_index u_index (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pix_valid (pix_valid),
		.pix       (pix),
		.blocked   (blocked),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.src_index (src_index),
		.dst_index (dst_index),
		.row_end   (row_end),
		.frame_end (frame_end)
	);

endmodule
